>>> hdl/bedo_pkg.sv
// ----------------------------------------------------------------------------
// bedo_pkg
// Shared types, constants and widths of the band energy onset detector.
// ----------------------------------------------------------------------------
package bedo_pkg;

  // history ring depth per band, and widths that follow from it
  // depth is a power of two so the mean and variance divisions are shifts
  localparam int HISTORY_DEPTH = 32;
  localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
  localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int HIST_ADDR_W   = HIST_IDX_W + 1;
  localparam int HIST_ENTRIES  = 2 * HISTORY_DEPTH;
  localparam int SUM_W         = 16 + HIST_IDX_W;
  localparam int SQS_W         = 32 + HIST_IDX_W;
  localparam int VNUM_W        = 32 + 2 * HIST_IDX_W;

  // shared divider: 16 fraction bits of a 16-bit ratio
  localparam int DIV_W      = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int DVSR_W     = 16;

  // threshold arithmetic widths
  localparam int VAR_W   = 32;
  localparam int P225_W  = VAR_W + 8;
  localparam int MULT_W  = P225_W + 1;
  localparam int PROD_W  = MULT_W + 17;
  localparam int VarScale = 225;

  // run counter
  localparam logic [3:0] RUN_MAX = 4'd10;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_HOLD_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_BAND0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_BAND1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_BAND0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_BAND1 = 3'd6;

  // input and result items
  typedef struct packed {
    logic        band_index;
    logic [15:0] band_energy;
  } bedo_in_t;

  typedef struct packed {
    logic        band_tag;
    logic        onset_active;
    logic        above_threshold;
    logic [3:0]  run_length;
    logic [15:0] level;
  } bedo_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MEAN,
    ST_VAR,
    ST_MUL,
    ST_PROD,
    ST_DONE
  } bedo_state_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DVSR_W-1:0] rem_init;
    logic [DVSR_W-1:0] dvsr;
  } bedo_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } bedo_div_rsp_t;

  // history ring request and response
  typedef struct packed {
    logic        acc_start;
    logic        band;
    logic        push;
    logic [15:0] push_data;
  } bedo_hist_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
    logic [SQS_W-1:0] sumsq;
  } bedo_hist_rsp_t;

endpackage

>>> hdl/bedo_div.sv
// ----------------------------------------------------------------------------
// bedo_div
// Shared restoring divider, rem_init * 2^16 / dvsr, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bedo_div import bedo_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bedo_div_req_t req_i,
  output bedo_div_rsp_t rsp_o
);

  logic                 active_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVSR_W-1:0]    rem_q;
  logic [DVSR_W-1:0]    dvsr_q;
  logic [DIV_W-1:0]     quo_q;

  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              ge;
  logic [DVSR_W-1:0] rem_d;

  // one restoring step: shift in a zero bit, subtract if it fits
  always_comb begin
    trial = {rem_q, 1'b0};
    diff  = trial - {1'b0, dvsr_q};
    ge    = (trial >= {1'b0, dvsr_q});
    rem_d = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= DIV_CNT_W'(DIV_W);
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // operand and quotient registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      dvsr_q <= req_i.dvsr;
      quo_q  <= '0;
    end else if (active_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.busy = active_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

`ifndef SYNTHESIS
  // a new division never cuts into one in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !active_q)
    else $error("divider started while busy");
`endif

endmodule

>>> hdl/bedo_hist.sv
// ----------------------------------------------------------------------------
// bedo_hist
// Per-band energy rings in one memory, with a sum and sum of squares pass.
// ----------------------------------------------------------------------------
module bedo_hist import bedo_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bedo_hist_req_t req_i,
  output bedo_hist_rsp_t rsp_o
);

  logic [15:0]           mem_q [HIST_ENTRIES];
  logic [15:0]           rd_q;
  logic [HIST_IDX_W-1:0] ptr_q [2];
  logic                  full_q [2];
  logic                  band_q;
  logic                  issue_q;
  logic [HIST_CNT_W-1:0] cnt_q;
  logic                  s1_vld_q, s1_ok_q, s1_last_q;
  logic                  s2_vld_q, s2_last_q;
  logic [15:0]           x_q;
  logic [31:0]           sq_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SQS_W-1:0]      sumsq_q;
  logic                  done_q;

  logic [HIST_IDX_W-1:0]  slot;
  logic [HIST_ADDR_W-1:0] rd_addr;
  logic [HIST_ADDR_W-1:0] wr_addr;
  logic                   slot_ok;
  logic                   last_slot;
  logic [15:0]            x_in;

  // entries never written since reset read as zero
  always_comb begin
    slot      = cnt_q[HIST_IDX_W-1:0];
    rd_addr   = {band_q, slot};
    wr_addr   = {band_q, ptr_q[band_q]};
    slot_ok   = full_q[band_q] || (slot < ptr_q[band_q]);
    last_slot = (cnt_q == HIST_CNT_W'(HISTORY_DEPTH - 1));
    x_in      = s1_ok_q ? rd_q : 16'd0;
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_addr] <= req_i.push_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // read sweep, pointers and fill flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= 1'b0;
      cnt_q     <= '0;
      band_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      done_q    <= 1'b0;
      ptr_q[0]  <= '0;
      ptr_q[1]  <= '0;
      full_q[0] <= 1'b0;
      full_q[1] <= 1'b0;
    end else begin
      s1_vld_q <= issue_q;
      s2_vld_q <= s1_vld_q;
      done_q   <= s2_vld_q && s2_last_q;
      if (req_i.acc_start) begin
        issue_q <= 1'b1;
        cnt_q   <= '0;
        band_q  <= req_i.band;
      end else if (issue_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_slot) begin
          issue_q <= 1'b0;
        end
      end
      if (req_i.push) begin
        if (ptr_q[band_q] == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
          ptr_q[band_q]  <= '0;
          full_q[band_q] <= 1'b1;
        end else begin
          ptr_q[band_q] <= ptr_q[band_q] + 1'b1;
        end
      end
    end
  end

  // square and accumulate pipeline
  always_ff @(posedge clk_i) begin
    s1_ok_q   <= slot_ok;
    s1_last_q <= last_slot;
    s2_last_q <= s1_last_q;
    x_q       <= x_in;
    sq_q      <= x_in * x_in;
    if (req_i.acc_start) begin
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (s2_vld_q) begin
      sum_q   <= sum_q + SUM_W'(x_q);
      sumsq_q <= sumsq_q + SQS_W'(sq_q);
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.sum   = sum_q;
  assign rsp_o.sumsq = sumsq_q;

`ifndef SYNTHESIS
  // a sweep only starts once the previous one has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.acc_start |-> (!issue_q && !s1_vld_q && !s2_vld_q))
    else $error("history sweep restarted while running");
`endif

endmodule

>>> hdl/band_energy_onset_detector_core.sv
// ----------------------------------------------------------------------------
// band_energy_onset_detector_core
// Per-band onset detection from energy mean and variance over a history ring.
// ----------------------------------------------------------------------------
// Each item carries one band energy (band 0 kick, band 1 snare) and yields one
// result item: the raw above-threshold flag, the debounced onset flag, the run
// counter and the energy level against the band full scale. in_ready_o stays
// low from acceptance until the result enters the output register, which
// waits while that register is still occupied. The time is set by the sweep
// over the band's ring, which reads one memory entry per cycle, then the
// square and sum pipeline and a short tail for variance, threshold product
// and compare. Mean and variance come from shifts; the 16-step level division
// runs on the shared radix-2 divider during the sweep. A result waits in the
// output register, so the next item can be taken before it is consumed. The
// rings need no clearing pass after reset: a write pointer and a full flag per
// band mark which entries hold data. Configuration writes are meant to be
// issued only while no item is in flight.
// ----------------------------------------------------------------------------
module band_energy_onset_detector_core import bedo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bedo_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bedo_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [15:0] threshold_base_q;
  logic [3:0]  on_hold_q;
  logic [3:0]  off_hold_q;
  logic [15:0] floor_q [2];
  logic [15:0] full_scale_q [2];

  // sequencer and item registers
  bedo_state_e state_q, state_d;
  logic        band_q;
  logic [15:0] energy_q;
  logic        sat_q;
  logic        acc_seen_q;
  logic [15:0] level_q;
  logic [15:0] mean_q;
  logic [VAR_W-1:0]  var_q;
  logic [VNUM_W-1:0] dq_q, ss_q, vnum_q;
  logic signed [MULT_W-1:0] mult_q;
  logic signed [PROD_W-1:0] rhs_q;

  // per-band debounce state
  logic       last_raw_q [2];
  logic [3:0] run_q [2];
  logic       onset_q [2];

  // output register
  logic      out_valid_q;
  bedo_out_t out_q;

  // unit links
  bedo_div_req_t  div_req;
  bedo_div_rsp_t  div_rsp;
  bedo_hist_req_t hist_req;
  bedo_hist_rsp_t hist_rsp;

  // sequencer strobes
  logic take_in, cap_level, cap_mean, cap_var, finish;

  // datapath signals
  logic [15:0]              fs_in;
  logic [P225_W-1:0]        p225;
  logic signed [MULT_W-1:0] mult_d;
  logic signed [PROD_W-1:0] mult_ext, mean_ext, lhs;
  logic signed [16:0]       diff;
  logic                     raw;
  logic [3:0]               run_cur, run_new, hold;
  logic                     onset_new;

  bedo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bedo_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hist_req),
    .rsp_o  (hist_rsp)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_base_q <= 16'd5325;
      on_hold_q        <= 4'd2;
      off_hold_q       <= 4'd2;
      floor_q[0]       <= 16'd4817;
      floor_q[1]       <= 16'd934;
      full_scale_q[0]  <= 16'd16384;
      full_scale_q[1]  <= 16'd1638;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD_BASE:   threshold_base_q <= cfg_wdata_i;
        CFG_ON_HOLD_COUNT:    on_hold_q        <= cfg_wdata_i[3:0];
        CFG_OFF_HOLD_COUNT:   off_hold_q       <= cfg_wdata_i[3:0];
        CFG_FLOOR_BAND0:      floor_q[0]       <= cfg_wdata_i;
        CFG_FLOOR_BAND1:      floor_q[1]       <= cfg_wdata_i;
        CFG_FULL_SCALE_BAND0: full_scale_q[0]  <= cfg_wdata_i;
        CFG_FULL_SCALE_BAND1: full_scale_q[1]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // threshold and debounce datapath
  always_comb begin
    fs_in    = full_scale_q[in_data_i.band_index];
    p225     = P225_W'(var_q) * P225_W'(VarScale);
    mult_d   = $signed({5'b0, threshold_base_q, 20'b0}) - $signed({1'b0, p225});
    mult_ext = PROD_W'(mult_q);
    mean_ext = $signed(PROD_W'({1'b0, mean_q}));
    diff     = $signed({1'b0, energy_q}) - $signed({1'b0, floor_q[band_q]});
    lhs      = PROD_W'($signed({diff, 32'b0}));
    raw      = (lhs > rhs_q);
    run_cur  = run_q[band_q];
    if (raw == last_raw_q[band_q]) begin
      run_new = (run_cur < RUN_MAX) ? run_cur + 4'd1 : run_cur;
    end else begin
      run_new = 4'd0;
    end
    hold      = raw ? on_hold_q : off_hold_q;
    onset_new = (run_new >= hold) ? raw : onset_q[band_q];
  end

  // sequencer next state and unit requests
  always_comb begin
    state_d   = state_q;
    take_in   = 1'b0;
    cap_level = 1'b0;
    cap_mean  = 1'b0;
    cap_var   = 1'b0;
    finish    = 1'b0;

    div_req.start    = 1'b0;
    div_req.rem_init = DVSR_W'(in_data_i.band_energy);
    div_req.dvsr     = DVSR_W'(fs_in);

    hist_req.acc_start = 1'b0;
    hist_req.band      = in_data_i.band_index;
    hist_req.push      = 1'b0;
    hist_req.push_data = energy_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          take_in            = 1'b1;
          hist_req.acc_start = 1'b1;
          div_req.start      = 1'b1;
          state_d            = ST_ACC;
        end
      end
      ST_ACC: begin
        cap_level = div_rsp.done;
        if ((acc_seen_q || hist_rsp.done) && !div_rsp.busy) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cap_mean = 1'b1;
        state_d  = ST_VAR;
      end
      ST_VAR: begin
        cap_var = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_PROD;
      ST_PROD: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          finish        = 1'b1;
          hist_req.push = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      acc_seen_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      last_raw_q[0] <= 1'b0;
      last_raw_q[1] <= 1'b0;
      run_q[0]      <= 4'd0;
      run_q[1]      <= 4'd0;
      onset_q[0]    <= 1'b0;
      onset_q[1]    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_in) begin
        acc_seen_q <= 1'b0;
      end else if (hist_rsp.done) begin
        acc_seen_q <= 1'b1;
      end
      if (finish) begin
        out_valid_q        <= 1'b1;
        last_raw_q[band_q] <= raw;
        run_q[band_q]      <= run_new;
        onset_q[band_q]    <= onset_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      band_q   <= in_data_i.band_index;
      energy_q <= in_data_i.band_energy;
      sat_q    <= (in_data_i.band_energy >= fs_in);
    end
    if (cap_level) begin
      level_q <= sat_q ? 16'hFFFF : div_rsp.quo;
    end
    // mean and variance: divisions by depth and depth squared are shifts
    if (cap_mean) begin
      mean_q <= hist_rsp.sum[SUM_W-1:HIST_IDX_W];
    end
    if (cap_var) begin
      var_q <= vnum_q[VNUM_W-1:2*HIST_IDX_W];
    end
    // variance numerator from the finished sums
    dq_q   <= VNUM_W'(hist_rsp.sumsq) * VNUM_W'(HISTORY_DEPTH);
    ss_q   <= VNUM_W'(hist_rsp.sum) * VNUM_W'(hist_rsp.sum);
    vnum_q <= dq_q - ss_q;
    if (state_q == ST_MUL) begin
      mult_q <= mult_d;
    end
    if (state_q == ST_PROD) begin
      rhs_q <= mult_ext * mean_ext;
    end
    if (finish) begin
      out_q.band_tag        <= band_q;
      out_q.onset_active    <= onset_new;
      out_q.above_threshold <= raw;
      out_q.run_length      <= run_new;
      out_q.level           <= level_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // one item at a time: taking an item closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  // a finished result waits while the output register is still occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result overwrote a pending output item");

  // run counter saturates at ten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.run_length <= RUN_MAX))
    else $error("run length beyond saturation");
`endif

endmodule
